FILE: hdl/key_matrix_press_hold_classifier_assert.svh
// ----------------------------------------------------------------------------
// key matrix press/hold classifier assertion macros
// concurrent assertion shorthands clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef KEY_MATRIX_PRESS_HOLD_CLASSIFIER_ASSERT_SVH
`define KEY_MATRIX_PRESS_HOLD_CLASSIFIER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define KMPH_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define KMPH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/kmph_pkg.sv
// ----------------------------------------------------------------------------
// kmph_pkg
// shared constants, phase codes and the item record passed along the key chain
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kmph_pkg;

    localparam int KEY_ROWS  = 2;
    localparam int KEY_COLS  = 7;
    localparam int NUM_KEYS  = KEY_ROWS * KEY_COLS;
    localparam int TIME_W    = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 8;

    localparam int S_TDATA_W = ((NUM_KEYS + TIME_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((2 + 2 * NUM_KEYS + 7) / 8) * 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SCAN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HOLD     = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] MIN_SCAN_RESET = CFG_W'(10);
    localparam logic [CFG_W-1:0] HOLD_RESET     = CFG_W'(500);

    // per-key phase codes
    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_PRESSED  = 2'd1;
    localparam logic [1:0] PH_HOLD     = 2'd2;
    localparam logic [1:0] PH_RELEASED = 2'd3;

    typedef struct packed {
        logic                valid;
        logic                scanned;
        logic                active;
        logic [NUM_KEYS-1:0] closed;
        logic [NUM_KEYS-1:0] short_mask;
        logic [NUM_KEYS-1:0] long_mask;
        logic [TIME_W-1:0]   now_ms;
    } kmph_item_t;

endpackage

FILE: hdl/kmph_gate.sv
// ----------------------------------------------------------------------------
// kmph_gate
// scan interval gate: tags each sample as processed or rejected, head register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kmph_gate
    import kmph_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [NUM_KEYS-1:0] key_closed_mask,
    input  logic [TIME_W-1:0]   now_ms,
    input  logic [CFG_W-1:0]    min_scan_interval_ms,
    input  logic                down_ready,
    output kmph_item_t          item
);

    kmph_item_t        item_reg;
    kmph_item_t        item_next;
    logic [TIME_W-1:0] last_scan_reg;
    logic [TIME_W-1:0] last_scan_next;
    logic [TIME_W-1:0] elapsed;
    logic              pass;
    logic              take;

    assign in_ready = !item_reg.valid || down_ready;
    assign take     = in_valid && in_ready;
    assign elapsed  = now_ms - last_scan_reg;
    assign pass     = elapsed > TIME_W'(min_scan_interval_ms);

    always_comb
    begin
        item_next            = item_reg;
        last_scan_next       = last_scan_reg;
        if (in_ready)
        begin
            item_next.valid      = in_valid;
            item_next.scanned    = pass;
            item_next.active     = 1'b0;
            item_next.closed     = key_closed_mask;
            item_next.short_mask = '0;
            item_next.long_mask  = '0;
            item_next.now_ms     = now_ms;
        end
        if (take && pass)
        begin
            last_scan_next = now_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg      <= '0;
            last_scan_reg <= '0;
        end
        else
        begin
            item_reg      <= item_next;
            last_scan_reg <= last_scan_next;
        end
    end

    assign item = item_reg;

endmodule

FILE: hdl/kmph_cell.sv
// ----------------------------------------------------------------------------
// kmph_cell
// one key: phase machine and press start time, steps as a scan passes through
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kmph_cell
    import kmph_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  kmph_item_t       item_in,
    output logic             up_ready,
    input  logic [CFG_W-1:0] hold_threshold_ms,
    input  logic             down_ready,
    output kmph_item_t       item_out
);

    kmph_item_t        item_reg;
    kmph_item_t        item_next;
    logic [1:0]        phase_reg;
    logic [1:0]        phase_next;
    logic [TIME_W-1:0] start_reg;
    logic [TIME_W-1:0] start_next;
    logic [TIME_W-1:0] elapsed;
    logic              closed;
    logic              load;
    logic              short_bit;
    logic              long_bit;
    logic              active;

    assign up_ready = !item_reg.valid || down_ready;
    assign load     = item_in.valid && up_ready;
    // this cell always looks at bit zero; the mask shifts one place per cell
    assign closed   = item_in.closed[0];
    assign elapsed  = item_in.now_ms - start_reg;

    always_comb
    begin
        phase_next = phase_reg;
        start_next = start_reg;
        short_bit  = 1'b0;
        long_bit   = 1'b0;
        active     = item_in.active;
        if (load && item_in.scanned)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (closed)
                    begin
                        phase_next = PH_PRESSED;
                        start_next = item_in.now_ms;
                        active     = 1'b1;
                    end
                end
                PH_PRESSED:
                begin
                    // hold check wins over an opening in the same scan
                    if (elapsed > TIME_W'(hold_threshold_ms))
                    begin
                        phase_next = PH_HOLD;
                        active     = 1'b1;
                    end
                    else if (!closed)
                    begin
                        phase_next = PH_RELEASED;
                        short_bit  = 1'b1;
                        active     = 1'b1;
                    end
                end
                PH_HOLD:
                begin
                    if (!closed)
                    begin
                        phase_next = PH_RELEASED;
                        long_bit   = 1'b1;
                        active     = 1'b1;
                    end
                end
                PH_RELEASED:
                begin
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        item_next = item_reg;
        if (up_ready)
        begin
            item_next.valid      = item_in.valid;
            item_next.scanned    = item_in.scanned;
            item_next.active     = active;
            item_next.closed     = item_in.closed >> 1;
            // own bit enters at the top; after the last cell key zero sits at bit zero
            item_next.short_mask = {short_bit, item_in.short_mask[NUM_KEYS-1:1]};
            item_next.long_mask  = {long_bit, item_in.long_mask[NUM_KEYS-1:1]};
            item_next.now_ms     = item_in.now_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg  <= '0;
            phase_reg <= PH_IDLE;
            start_reg <= '0;
        end
        else
        begin
            item_reg  <= item_next;
            phase_reg <= phase_next;
            start_reg <= start_next;
        end
    end

    assign item_out = item_reg;

endmodule

FILE: hdl/key_matrix_press_hold_classifier.sv
// ----------------------------------------------------------------------------
// key_matrix_press_hold_classifier
// classifies matrix key presses into short and long releases per scan
// ----------------------------------------------------------------------------
// usage:
//   s_* takes one matrix sample per transfer: closure bitmap plus ms timestamp.
//   m_* returns exactly one result per sample, in order: scanned flag,
//   activity flag, short release mask and long release mask.
//   cfg_* writes the scan interval (index 0) and hold threshold (index 1);
//   other indexes are ignored. write only while no sample is in flight.
// pipeline: between the input transfer and m_tvalid lie one gate register
//   plus one register per key cell, 14 cells in a row.
// throughput: one sample per cycle while m_tready is high; each cell steps its
//   key once per scanned sample, so the chain keeps 15 samples in flight.
// reset: all keys idle, press times and last scan time zero, interval 10 ms,
//   hold threshold 500 ms, no result pending.
// stall: a stalled m_* holds its result; the chain keeps filling its empty
//   stages, and s_tready drops only when every stage holds a sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module key_matrix_press_hold_classifier
    import kmph_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // key_closed_mask, now_ms
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // scanned, activity, short_release_mask,
                                            // long_release_mask
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [CFG_W-1:0] min_scan_reg;
    logic [CFG_W-1:0] min_scan_next;
    logic [CFG_W-1:0] hold_reg;
    logic [CFG_W-1:0] hold_next;
    kmph_item_t       chain [NUM_KEYS+1];
    logic [NUM_KEYS:0] rdy;
    kmph_item_t       last_item;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        min_scan_next = min_scan_reg;
        hold_next     = hold_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MIN_SCAN: min_scan_next = cfg_data;
                REG_HOLD:     hold_next     = cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_scan_reg <= MIN_SCAN_RESET;
            hold_reg     <= HOLD_RESET;
        end
        else
        begin
            min_scan_reg <= min_scan_next;
            hold_reg     <= hold_next;
        end
    end

    kmph_gate u_gate (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (s_tvalid),
        .in_ready             (s_tready),
        .key_closed_mask      (s_tdata[NUM_KEYS-1:0]),
        .now_ms               (s_tdata[NUM_KEYS +: TIME_W]),
        .min_scan_interval_ms (min_scan_reg),
        .down_ready           (rdy[0]),
        .item                 (chain[0])
    );

    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_cell
        kmph_cell u_cell (
            .clk               (clk),
            .rst_n             (rst_n),
            .item_in           (chain[k]),
            .up_ready          (rdy[k]),
            .hold_threshold_ms (hold_reg),
            .down_ready        (rdy[k+1]),
            .item_out          (chain[k+1])
        );
    end

    assign rdy[NUM_KEYS] = m_tready;
    assign last_item     = chain[NUM_KEYS];
    assign m_tvalid      = last_item.valid;
    assign m_tdata       = M_TDATA_W'({last_item.long_mask, last_item.short_mask,
                                       last_item.active, last_item.scanned});

endmodule

FILE: hdl/kmph_checker.sv
// ----------------------------------------------------------------------------
// kmph_checker
// port-level checks on the result channel of the classifier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "key_matrix_press_hold_classifier_assert.svh"

module kmph_checker
    import kmph_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic                scanned;
    logic                activity;
    logic [NUM_KEYS-1:0] short_rel;
    logic [NUM_KEYS-1:0] long_rel;

    assign scanned   = m_tdata[0];
    assign activity  = m_tdata[1];
    assign short_rel = m_tdata[2 +: NUM_KEYS];
    assign long_rel  = m_tdata[2 + NUM_KEYS +: NUM_KEYS];

    // a stalled result stays put
    `KMPH_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "result changed while stalled")

    // a rejected sample reports nothing
    `KMPH_ASSERT_SAME(a_reject_quiet, m_tvalid && !scanned,
        !activity && short_rel == '0 && long_rel == '0, "rejected scan reports activity")

    // a key cannot end both a short and a long press in one scan
    `KMPH_ASSERT_SAME(a_masks_disjoint, m_tvalid,
        (short_rel & long_rel) == '0, "short and long release overlap")

    // any release is a phase change
    `KMPH_ASSERT_SAME(a_release_active, m_tvalid && (short_rel != '0 || long_rel != '0),
        activity, "release without activity")

endmodule

bind key_matrix_press_hold_classifier kmph_checker u_kmph_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
